// ===== sv/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants of the sprite frame sequencer
// Holds the item mode codes, the internal operation and event codes, the
// configuration register map and the frame timer limits.
// ----------------------------------------------------------------------------
package sfs_pkg;

    // mode field of an input item
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;
    localparam logic [1:0] MODE_PAUSE = 2'd3;

    // configuration register map
    localparam int         CFG_INDEX_W     = 2;
    localparam int         CFG_DATA_W      = 7;
    localparam logic [1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] CFG_LOOP        = 2'd1;
    localparam logic [1:0] CFG_PING_PONG   = 2'd2;
    localparam logic [6:0] FRAME_COUNT_RST = 7'd1;

    // frame timer
    localparam int                    TIMER_BITS = 24;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX  = '1;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_WRITE,
        OP_START,
        OP_PAUSE
    } t_op;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_FRAME = 3'd1,
        EV_LOOP  = 3'd2,
        EV_PING  = 3'd3,
        EV_PONG  = 3'd4,
        EV_END   = 3'd5
    } t_event;

    typedef struct packed {
        logic [6:0] frame_count;
        logic       loop_enable;
        logic       ping_pong_enable;
    } t_cfg;

    // control part of a classified command
    typedef struct packed {
        t_op  op;
        logic write_ok;
        logic pause_value;
    } t_cmd_ctl;

endpackage

// ===== sv/sfs_ram.sv =====
// ----------------------------------------------------------------------------
// sfs_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sfs_fifo.sv =====
// ----------------------------------------------------------------------------
// sfs_fifo: small register queue
// Flop-based FIFO with a fill count; the head word is shown combinationally.
// ----------------------------------------------------------------------------
module sfs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic [WIDTH-1:0]           o_data
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNW-1:0]   r_count, n_count;
    logic             do_push, do_pop;

    assign do_push = i_push && (r_count != CNW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];

endmodule

// ===== sv/sfs_front.sv =====
// ----------------------------------------------------------------------------
// sfs_front: input side of the sprite frame sequencer
// Accepts items, decodes the mode into an operation and queues the command.
// ----------------------------------------------------------------------------
module sfs_front #(
    parameter int MAX_FRAMES = 64,
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_mode,
    input  logic [TIME_BITS-1:0]          i_delta_ticks,
    input  logic [$clog2(MAX_FRAMES)-1:0] i_entry_index,
    input  logic [COORD_BITS-1:0]         i_entry_x,
    input  logic [COORD_BITS-1:0]         i_entry_y,
    input  logic [COORD_BITS-1:0]         i_entry_width,
    input  logic [COORD_BITS-1:0]         i_entry_height,
    input  logic [TIME_BITS-1:0]          i_entry_duration,
    input  logic                          i_pause_value,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_pop,
    output sfs_pkg::t_cmd_ctl             o_cmd_ctl,
    output logic [TIME_BITS-1:0]          o_cmd_delta,
    output logic [$clog2(MAX_FRAMES)-1:0] o_cmd_index,
    output logic [4*COORD_BITS+TIME_BITS-1:0] o_cmd_entry
);

    localparam int PW      = $clog2(MAX_FRAMES);
    localparam int ENTRY_W = 4 * COORD_BITS + TIME_BITS;
    localparam int CTL_W   = $bits(sfs_pkg::t_cmd_ctl);
    localparam int CMD_W   = CTL_W + TIME_BITS + PW + ENTRY_W;
    localparam int DEPTH   = 4;
    localparam int CNW     = $clog2(DEPTH + 1);

    sfs_pkg::t_cmd_ctl  ctl;
    logic               push;
    logic [CMD_W-1:0]   push_data;
    logic [CMD_W-1:0]   head;
    logic [CNW-1:0]     count;

    // classify the item
    always_comb begin
        ctl.write_ok    = 32'(i_entry_index) < 32'(MAX_FRAMES);
        ctl.pause_value = i_pause_value;
        unique case (i_mode)
            sfs_pkg::MODE_TICK:  ctl.op = sfs_pkg::OP_TICK;
            sfs_pkg::MODE_WRITE: ctl.op = sfs_pkg::OP_WRITE;
            sfs_pkg::MODE_START: ctl.op = sfs_pkg::OP_START;
            default:             ctl.op = sfs_pkg::OP_PAUSE;
        endcase
    end

    assign o_ready   = (count != CNW'(DEPTH));
    assign push      = i_valid && o_ready;
    assign push_data = {ctl, i_delta_ticks, i_entry_index,
                        i_entry_x, i_entry_y, i_entry_width, i_entry_height,
                        i_entry_duration};

    sfs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (i_cmd_pop),
        .o_count (count),
        .o_data  (head)
    );

    assign o_cmd_valid = (count != '0);
    assign o_cmd_ctl   = sfs_pkg::t_cmd_ctl'(head[CMD_W-1 -: CTL_W]);
    assign o_cmd_delta = head[PW+ENTRY_W +: TIME_BITS];
    assign o_cmd_index = head[ENTRY_W +: PW];
    assign o_cmd_entry = head[ENTRY_W-1:0];

endmodule

// ===== sv/sfs_back.sv =====
// ----------------------------------------------------------------------------
// sfs_back: execution side of the sprite frame sequencer
// Runs one command per cycle if the result queue has room, against the frame
// table and play state; queues event and current rectangle as a result word.
// ----------------------------------------------------------------------------
module sfs_back #(
    parameter int MAX_FRAMES = 64,
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfs_pkg::t_cfg                 i_cfg,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_pop,
    input  sfs_pkg::t_cmd_ctl             i_cmd_ctl,
    input  logic [TIME_BITS-1:0]          i_cmd_delta,
    input  logic [$clog2(MAX_FRAMES)-1:0] i_cmd_index,
    input  logic [4*COORD_BITS+TIME_BITS-1:0] i_cmd_entry,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_event_code,
    output logic [$clog2(MAX_FRAMES)-1:0] o_frame_now,
    output logic [COORD_BITS-1:0]         o_sprite_x,
    output logic [COORD_BITS-1:0]         o_sprite_y,
    output logic [COORD_BITS-1:0]         o_sprite_width,
    output logic [COORD_BITS-1:0]         o_sprite_height,
    output logic                          o_is_playing,
    output logic                          o_is_reversed
);

    localparam int PW        = $clog2(MAX_FRAMES);
    localparam int CW        = $clog2(MAX_FRAMES + 1);
    localparam int ENTRY_W   = 4 * COORD_BITS + TIME_BITS;
    localparam int RECT_W    = 4 * COORD_BITS;
    localparam int TB        = sfs_pkg::TIMER_BITS;
    localparam int CMPW      = (TIME_BITS > TB) ? TIME_BITS : TB;
    localparam int SW        = CMPW + 1;
    localparam int RES_W     = 3 + PW + RECT_W + 2;
    localparam int OUT_DEPTH = 4;
    localparam int OCW       = $clog2(OUT_DEPTH + 1);

    // play state
    logic [PW-1:0]  r_pos, n_pos;
    logic [TB-1:0]  r_timer, n_timer;
    logic           r_rev, n_rev;
    logic           r_play, n_play;
    logic           r_pause, n_pause;

    // table read and write-to-read bypass
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_q;
    logic               r_hit, n_hit;
    logic [ENTRY_W-1:0] r_hit_data;
    logic [ENTRY_W-1:0] cur_entry;
    logic [TIME_BITS-1:0] cur_dur;

    // tick arithmetic
    logic [CW-1:0]  count;
    logic [SW-1:0]  tsum;
    logic [TB-1:0]  t_sat;
    logic           pos_in, due, at_last;
    logic [PW-1:0]  back2, last, restart;

    sfs_pkg::t_event ev;
    logic            e_fire;

    // result stage
    logic            r_res_valid;
    sfs_pkg::t_event r_res_ev;
    logic [PW-1:0]   r_res_pos;
    logic            r_res_play, r_res_rev;
    logic [RES_W-1:0] res_data, out_data;
    logic [OCW-1:0]  out_count;

    // fire only with a guaranteed slot in the output queue
    assign e_fire    = i_cmd_valid && ((out_count + OCW'(r_res_valid)) < OCW'(OUT_DEPTH));
    assign o_cmd_pop = e_fire;

    assign cur_entry = r_hit ? r_hit_data : ram_q;
    assign cur_dur   = cur_entry[TIME_BITS-1:0];

    always_comb begin
        if (i_cfg.frame_count == '0) begin
            count = CW'(1);
        end else if (32'(i_cfg.frame_count) > 32'(MAX_FRAMES)) begin
            count = CW'(MAX_FRAMES);
        end else begin
            count = CW'(i_cfg.frame_count);
        end
    end

    assign tsum    = SW'(r_timer) + SW'(i_cmd_delta);
    assign t_sat   = (tsum > SW'(sfs_pkg::TIMER_MAX)) ? sfs_pkg::TIMER_MAX : tsum[TB-1:0];
    assign pos_in  = CW'(r_pos) < count;
    assign due     = CMPW'(t_sat) >= CMPW'(cur_dur);
    assign at_last = (CW'(r_pos) + CW'(1)) >= count;
    assign back2   = (count >= CW'(2)) ? PW'(count - CW'(2)) : '0;
    assign last    = PW'(count - CW'(1));
    assign restart = (count >= CW'(2)) ? PW'(1) : '0;

    always_comb begin
        n_pos   = r_pos;
        n_timer = r_timer;
        n_rev   = r_rev;
        n_play  = r_play;
        n_pause = r_pause;
        ev      = sfs_pkg::EV_NONE;
        ram_we  = 1'b0;
        if (e_fire) begin
            unique case (i_cmd_ctl.op)
                sfs_pkg::OP_TICK: begin
                    if (r_play && !r_pause) begin
                        n_timer = t_sat;
                        if (pos_in && due) begin
                            n_timer = '0;
                            if (!r_rev) begin
                                if (at_last) begin
                                    if (i_cfg.ping_pong_enable) begin
                                        n_rev = 1'b1;
                                        n_pos = back2;
                                        ev    = sfs_pkg::EV_PING;
                                    end else if (i_cfg.loop_enable) begin
                                        n_pos = '0;
                                        ev    = sfs_pkg::EV_LOOP;
                                    end else begin
                                        n_pos  = last;
                                        n_play = 1'b0;
                                        ev     = sfs_pkg::EV_END;
                                    end
                                end else begin
                                    n_pos = r_pos + PW'(1);
                                    ev    = sfs_pkg::EV_FRAME;
                                end
                            end else if (r_pos == '0) begin
                                if (i_cfg.loop_enable) begin
                                    n_rev = 1'b0;
                                    n_pos = restart;
                                    ev    = sfs_pkg::EV_PONG;
                                end else begin
                                    n_play = 1'b0;
                                    ev     = sfs_pkg::EV_END;
                                end
                            end else begin
                                n_pos = r_pos - PW'(1);
                                ev    = sfs_pkg::EV_FRAME;
                            end
                        end
                    end
                end
                sfs_pkg::OP_WRITE: begin
                    ram_we = i_cmd_ctl.write_ok;
                end
                sfs_pkg::OP_START: begin
                    n_pos   = '0;
                    n_timer = '0;
                    n_rev   = 1'b0;
                    n_play  = 1'b1;
                    n_pause = 1'b0;
                end
                sfs_pkg::OP_PAUSE: begin
                    n_pause = i_cmd_ctl.pause_value;
                end
                default: ;
            endcase
        end
    end

    // read the entry at the next position every cycle so the data lines up
    // with the position register; catch a same-cycle write to that entry
    assign n_hit = ram_we && (i_cmd_index == n_pos);

    sfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_FRAMES)
    ) u_frame_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd_index),
        .i_wdata (i_cmd_entry),
        .i_raddr (n_pos),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_timer     <= '0;
            r_rev       <= 1'b0;
            r_play      <= 1'b0;
            r_pause     <= 1'b0;
            r_hit       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_timer     <= n_timer;
            r_rev       <= n_rev;
            r_play      <= n_play;
            r_pause     <= n_pause;
            r_hit       <= n_hit;
            r_res_valid <= e_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_data <= i_cmd_entry;
        if (e_fire) begin
            r_res_ev   <= ev;
            r_res_pos  <= n_pos;
            r_res_play <= n_play;
            r_res_rev  <= n_rev;
        end
    end

    // rectangle comes from the table read issued with the command
    assign res_data = {r_res_ev, r_res_pos, cur_entry[ENTRY_W-1 -: RECT_W],
                       r_res_play, r_res_rev};

    sfs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_res_valid),
        .i_data  (res_data),
        .i_pop   (o_valid && i_ready),
        .o_count (out_count),
        .o_data  (out_data)
    );

    assign o_valid         = (out_count != '0);
    assign o_event_code    = out_data[RES_W-1 -: 3];
    assign o_frame_now     = out_data[RES_W-4 -: PW];
    assign o_sprite_x      = out_data[2+3*COORD_BITS +: COORD_BITS];
    assign o_sprite_y      = out_data[2+2*COORD_BITS +: COORD_BITS];
    assign o_sprite_width  = out_data[2+COORD_BITS +: COORD_BITS];
    assign o_sprite_height = out_data[2 +: COORD_BITS];
    assign o_is_playing    = out_data[1];
    assign o_is_reversed   = out_data[0];

endmodule

// ===== sv/sprite_frame_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_unit: sprite animation frame sequencer
// Plays one animation from a frame table of rectangles and durations.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready): one word per step. Mode selects a tick
//   (advance the frame timer by i_delta_ticks), a frame table write, start of
//   play, or a pause flag update.
//   Output channel (o_valid/i_ready): exactly one result word per input word,
//   in order: event code, current frame and its rectangle, play and reverse
//   flags after the step.
//   Config channel (i_cfg_valid/o_cfg_ready): frame count, loop enable and
//   ping-pong enable; always ready, write only while the block is idle.
//   Throughput: one word per cycle sustained while the receiver keeps up.
//   The table read for the next frame is issued from the next-position
//   value, so the duration compare of the following tick finds its data
//   registered with no bubble. Path of a word: command queue, execute,
//   then the result/table read stage.
//   Reset: play state cleared, frame count 1, loop and ping-pong off; the
//   frame table holds garbage until written.
//   Stall: a four-word result queue absorbs the receiver stalling; execute
//   holds when it is full, then the command queue fills and o_ready drops.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_unit #(
    parameter int MAX_FRAMES = 64,
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sfs_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input items
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_mode,
    input  logic [TIME_BITS-1:0]                i_delta_ticks,
    input  logic [$clog2(MAX_FRAMES)-1:0]       i_entry_index,
    input  logic [COORD_BITS-1:0]               i_entry_x,
    input  logic [COORD_BITS-1:0]               i_entry_y,
    input  logic [COORD_BITS-1:0]               i_entry_width,
    input  logic [COORD_BITS-1:0]               i_entry_height,
    input  logic [TIME_BITS-1:0]                i_entry_duration,
    input  logic                                i_pause_value,
    // results
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [2:0]                          o_event_code,
    output logic [$clog2(MAX_FRAMES)-1:0]       o_frame_now,
    output logic [COORD_BITS-1:0]               o_sprite_x,
    output logic [COORD_BITS-1:0]               o_sprite_y,
    output logic [COORD_BITS-1:0]               o_sprite_width,
    output logic [COORD_BITS-1:0]               o_sprite_height,
    output logic                                o_is_playing,
    output logic                                o_is_reversed
);

    localparam int PW      = $clog2(MAX_FRAMES);
    localparam int ENTRY_W = 4 * COORD_BITS + TIME_BITS;

    sfs_pkg::t_cfg     r_cfg;
    logic              cfg_wr;

    logic                 cmd_valid;
    logic                 cmd_pop;
    sfs_pkg::t_cmd_ctl    cmd_ctl;
    logic [TIME_BITS-1:0] cmd_delta;
    logic [PW-1:0]        cmd_index;
    logic [ENTRY_W-1:0]   cmd_entry;

    // config registers: always take the write, drop unknown indexes
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_count      <= sfs_pkg::FRAME_COUNT_RST;
            r_cfg.loop_enable      <= 1'b0;
            r_cfg.ping_pong_enable <= 1'b0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                sfs_pkg::CFG_FRAME_COUNT: r_cfg.frame_count      <= i_cfg_data;
                sfs_pkg::CFG_LOOP:        r_cfg.loop_enable      <= i_cfg_data[0];
                sfs_pkg::CFG_PING_PONG:   r_cfg.ping_pong_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // front: accept and classify, queue commands
    sfs_front #(
        .MAX_FRAMES (MAX_FRAMES),
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_delta_ticks    (i_delta_ticks),
        .i_entry_index    (i_entry_index),
        .i_entry_x        (i_entry_x),
        .i_entry_y        (i_entry_y),
        .i_entry_width    (i_entry_width),
        .i_entry_height   (i_entry_height),
        .i_entry_duration (i_entry_duration),
        .i_pause_value    (i_pause_value),
        .o_cmd_valid      (cmd_valid),
        .i_cmd_pop        (cmd_pop),
        .o_cmd_ctl        (cmd_ctl),
        .o_cmd_delta      (cmd_delta),
        .o_cmd_index      (cmd_index),
        .o_cmd_entry      (cmd_entry)
    );

    // back: execute against the frame table, queue results
    sfs_back #(
        .MAX_FRAMES (MAX_FRAMES),
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd_valid     (cmd_valid),
        .o_cmd_pop       (cmd_pop),
        .i_cmd_ctl       (cmd_ctl),
        .i_cmd_delta     (cmd_delta),
        .i_cmd_index     (cmd_index),
        .i_cmd_entry     (cmd_entry),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_event_code    (o_event_code),
        .o_frame_now     (o_frame_now),
        .o_sprite_x      (o_sprite_x),
        .o_sprite_y      (o_sprite_y),
        .o_sprite_width  (o_sprite_width),
        .o_sprite_height (o_sprite_height),
        .o_is_playing    (o_is_playing),
        .o_is_reversed   (o_is_reversed)
    );

endmodule
